// File: rtl/core/aabb_pkg.sv
// Package: shared types and constants of the box collision table.
`default_nettype none
package aabb_pkg;
   localparam int MAX_BOXES  = 64;
   localparam int MAX_HITS   = 8;
   localparam int IDX_W      = 6;
   localparam int CNT_W      = 7;
   localparam int PAIR_W     = 11;
   localparam int HCNT_W     = 4;
   localparam int HIDX_W     = 3;
   localparam int LIST_AW    = IDX_W + HIDX_W;
   localparam logic [PAIR_W-1:0] PAIR_MAX = 11'd2047;

   typedef enum logic [2:0] {
      ACT_APPEND  = 3'd0,
      ACT_REWRITE = 3'd1,
      ACT_CLEAR   = 3'd2,
      ACT_UPDATE  = 3'd3,
      ACT_QUERY   = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic        en;
      logic [30:0] h;
      logic [30:0] w;
      logic [31:0] y;
      logic [31:0] x;
   } box_type;

   typedef struct packed {
      logic req_ready;
      logic ld_req;
      logic set_full;
      logic set_range;
      logic mul_x;
      logic mul_y;
      logic wr_box;
      logic clear_all;
      logic upd_start;
      logic rd_row;
      logic ld_row;
      logic rec_i;
      logic rec_j;
      logic adv_j;
      logic count_ovf;
      logic wb_row;
      logic q_start;
      logic q_scan;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       full;
      logic       bad_a;
      logic       bad_q;
      logic       rows_done;
      logic       row_en;
      logic       row_end;
      logic       pair_hit;
      logic       room;
      logic       q_last;
      logic       rsp_free;
   } stat_type;
endpackage
`default_nettype wire

// File: rtl/core/aabb_if.sv
// Interfaces: request and response channels of the box collision table.
`default_nettype none
interface aabb_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic [5:0]         index_a;
   logic [5:0]         index_b;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic [30:0]        size_x;
   logic [30:0]        size_y;
   logic               enabled;
   logic               has_parent;
   logic signed [31:0] parent_x;
   logic signed [31:0] parent_y;
   logic [15:0]        parent_scale;
   modport source (output valid, action, index_a, index_b, pos_x, pos_y, size_x, size_y,
                   enabled, has_parent, parent_x, parent_y, parent_scale, input ready);
   modport sink (input valid, action, index_a, index_b, pos_x, pos_y, size_x, size_y,
                 enabled, has_parent, parent_x, parent_y, parent_scale, output ready);
endinterface

interface aabb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        collided;
   logic [6:0]  box_count;
   logic [10:0] pair_count;
   logic [10:0] overflow_count;
   modport source (output valid, status, collided, box_count, pair_count, overflow_count,
                   input ready);
   modport sink (input valid, status, collided, box_count, pair_count, overflow_count,
                 output ready);
endinterface
`default_nettype wire

// File: rtl/core/aabb_ctrl.sv
// Controller: sequences actions, pair sweep and query scan.
`default_nettype none
module aabb_ctrl
   import aabb_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire stat_type stat,
   output cmd_type       cmd
);
   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_DECODE = 12'b000000000010,
      S_MULX   = 12'b000000000100,
      S_MULY   = 12'b000000001000,
      S_WRB    = 12'b000000010000,
      S_RDI    = 12'b000000100000,
      S_LDI    = 12'b000001000000,
      S_TEST   = 12'b000010000000,
      S_HIT2   = 12'b000100000000,
      S_WBI    = 12'b001000000000,
      S_QSCAN  = 12'b010000000000,
      S_DONE   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (req_valid) begin
               cmd.ld_req = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.action)
               ACT_APPEND: begin
                  if (stat.full) begin
                     cmd.set_full = 1'b1;
                     state_in     = S_DONE;
                  end else state_in = S_MULX;
               end
               ACT_REWRITE: begin
                  if (stat.bad_a) begin
                     cmd.set_range = 1'b1;
                     state_in      = S_DONE;
                  end else state_in = S_MULX;
               end
               ACT_CLEAR: begin
                  cmd.clear_all = 1'b1;
                  state_in      = S_DONE;
               end
               ACT_UPDATE: begin
                  cmd.upd_start = 1'b1;
                  state_in      = S_RDI;
               end
               ACT_QUERY: begin
                  if (stat.bad_q) begin
                     cmd.set_range = 1'b1;
                     state_in      = S_DONE;
                  end else begin
                     cmd.q_start = 1'b1;
                     state_in    = S_QSCAN;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_MULX: begin
            cmd.mul_x = 1'b1;
            state_in  = S_MULY;
         end
         S_MULY: begin
            cmd.mul_y = 1'b1;
            state_in  = S_WRB;
         end
         S_WRB: begin
            cmd.wr_box = 1'b1;
            state_in   = S_DONE;
         end
         S_RDI: begin
            if (stat.rows_done) state_in = S_DONE;
            else begin
               cmd.rd_row = 1'b1;
               state_in   = S_LDI;
            end
         end
         S_LDI: begin
            cmd.ld_row = 1'b1;
            state_in   = stat.row_en ? S_TEST : S_WBI;
         end
         S_TEST: begin
            priority if (stat.row_end) state_in = S_WBI;
            else if (stat.pair_hit && stat.room) begin
               cmd.rec_i = 1'b1;
               state_in  = S_HIT2;
            end else begin
               cmd.adv_j     = 1'b1;
               cmd.count_ovf = stat.pair_hit;
            end
         end
         S_HIT2: begin
            cmd.rec_j = 1'b1;
            cmd.adv_j = 1'b1;
            state_in  = S_TEST;
         end
         S_WBI: begin
            cmd.wb_row = 1'b1;
            state_in   = S_RDI;
         end
         S_QSCAN: begin
            cmd.q_scan = 1'b1;
            if (stat.q_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// File: rtl/core/aabb_dpath.sv
// Datapath: box store, hit lists, world transform, overlap test and response register.
`default_nettype none
module aabb_dpath
   import aabb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   aabb_req_if.sink     req_chan,
   aabb_rsp_if.source   rsp_chan,
   input  wire cmd_type cmd,
   output stat_type     stat
);
   // latched transaction
   logic [2:0]         action_ff;
   logic [IDX_W-1:0]   ia_ff, ib_ff;
   logic signed [31:0] lx_ff, ly_ff, parx_ff, pary_ff;
   logic [30:0]        sx_ff, sy_ff;
   logic               en_ff, hp_ff;
   logic [15:0]        scale_ff;

   logic [CNT_W-1:0]   count_ff;
   logic [PAIR_W-1:0]  pairs_ff, ovf_ff;
   logic [1:0]         status_ff;
   logic               coll_ff;
   logic signed [48:0] prod_ff, prod_in;
   logic [31:0]        wx_ff;
   logic [CNT_W-1:0]   i_ff, j_ff;
   logic [HIDX_W-1:0]  k_ff;
   logic [HCNT_W-1:0]  cnt_i_ff;
   box_type            a_ff;

   box_type            box_mem [MAX_BOXES];
   logic [HCNT_W-1:0]  cnt_mem [MAX_BOXES];
   logic [MAX_BOXES-1:0] cnt_valid_ff;
   logic [IDX_W-1:0]   list_mem [MAX_BOXES*MAX_HITS];
   box_type            box_rd_ff;
   logic [HCNT_W-1:0]  cnt_rd_ff;
   logic [IDX_W-1:0]   list_rd_ff;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic               rsp_coll_ff;
   logic [CNT_W-1:0]   rsp_count_ff;
   logic [PAIR_W-1:0]  rsp_pairs_ff, rsp_ovf_ff;

   function automatic logic [31:0] world(input logic signed [31:0] loc,
                                         input logic signed [31:0] par,
                                         input logic signed [48:0] prod,
                                         input logic hp);
      logic signed [41:0] sum;
      begin
         sum = 42'(par) + 42'(prod >>> 8);
         if (!hp) world = loc;
         else if (sum > 42'sd2147483647) world = 32'h7FFF_FFFF;
         else if (sum < -42'sd2147483648) world = 32'h8000_0000;
         else world = sum[31:0];
      end
   endfunction

   function automatic logic lt_sum(input logic [31:0] p, input logic [31:0] q,
                                   input logic [30:0] qs);
      logic signed [33:0] lhs, rhs;
      begin
         lhs    = 34'($signed(p));
         rhs    = 34'($signed(q)) + $signed({3'b000, qs});
         lt_sum = lhs < rhs;
      end
   endfunction

   logic [CNT_W-1:0]  i_next, j_next;
   logic [IDX_W-1:0]  rd_idx;
   logic              rd_en;
   logic [CNT_W-1:0]  rd_sel;
   logic              overlap;
   logic [LIST_AW-1:0] list_wa, list_ra;
   logic [IDX_W-1:0]  list_wd;
   logic              list_we;
   logic [HIDX_W-1:0] k_next;

   assign i_next = i_ff + 1'b1;
   assign j_next = j_ff + 1'b1;
   assign k_next = k_ff + 1'b1;

   always_comb begin
      priority if (cmd.rd_row) rd_sel = i_ff;
      else if (cmd.ld_row) rd_sel = i_next;
      else rd_sel = j_next;
   end
   assign rd_en  = cmd.rd_row | cmd.ld_row | cmd.adv_j | cmd.q_start;
   assign rd_idx = cmd.q_start ? ia_ff : rd_sel[IDX_W-1:0];

   assign overlap = lt_sum(a_ff.x, box_rd_ff.x, box_rd_ff.w)
                 && lt_sum(box_rd_ff.x, a_ff.x, a_ff.w)
                 && lt_sum(a_ff.y, box_rd_ff.y, box_rd_ff.h)
                 && lt_sum(box_rd_ff.y, a_ff.y, a_ff.h);

   assign list_we = cmd.rec_i | cmd.rec_j;
   assign list_wa = cmd.rec_i ? {i_ff[IDX_W-1:0], cnt_i_ff[HIDX_W-1:0]}
                              : {j_ff[IDX_W-1:0], cnt_rd_ff[HIDX_W-1:0]};
   assign list_wd = cmd.rec_i ? j_ff[IDX_W-1:0] : i_ff[IDX_W-1:0];
   assign list_ra = cmd.q_start ? {ia_ff, {HIDX_W{1'b0}}} : {ia_ff, k_next};

   assign prod_in = $signed(cmd.mul_x ? lx_ff : ly_ff) * $signed({1'b0, scale_ff});

   // memories
   always_ff @(posedge clock) begin
      if (cmd.wr_box)
         box_mem[(action_ff == ACT_APPEND) ? count_ff[IDX_W-1:0] : ia_ff] <=
            '{en: en_ff, h: sy_ff, w: sx_ff, x: wx_ff,
              y: world(ly_ff, pary_ff, prod_ff, hp_ff)};
      if (rd_en) box_rd_ff <= box_mem[rd_idx];
      if (cmd.wb_row) cnt_mem[i_ff[IDX_W-1:0]] <= cnt_i_ff;
      else if (cmd.rec_j) cnt_mem[j_ff[IDX_W-1:0]] <= cnt_rd_ff + 1'b1;
      if (rd_en) cnt_rd_ff <= cnt_valid_ff[rd_idx] ? cnt_mem[rd_idx] : '0;
      if (list_we) list_mem[list_wa] <= list_wd;
      if (cmd.q_start || cmd.q_scan) list_rd_ff <= list_mem[list_ra];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.ld_req) begin
         action_ff <= req_chan.action;
         ia_ff     <= req_chan.index_a;
         ib_ff     <= req_chan.index_b;
         lx_ff     <= req_chan.pos_x;
         ly_ff     <= req_chan.pos_y;
         sx_ff     <= req_chan.size_x;
         sy_ff     <= req_chan.size_y;
         en_ff     <= req_chan.enabled;
         hp_ff     <= req_chan.has_parent;
         parx_ff   <= req_chan.parent_x;
         pary_ff   <= req_chan.parent_y;
         scale_ff  <= req_chan.parent_scale;
      end
      if (cmd.mul_x || cmd.mul_y) prod_ff <= prod_in;
      if (cmd.mul_y) wx_ff <= world(lx_ff, parx_ff, prod_ff, hp_ff);
      if (cmd.ld_row) begin
         a_ff     <= box_rd_ff;
         cnt_i_ff <= cnt_rd_ff;
      end else if (cmd.rec_i) cnt_i_ff <= cnt_i_ff + 1'b1;
      if (cmd.upd_start) i_ff <= '0;
      else if (cmd.wb_row) i_ff <= i_next;
      if (cmd.ld_row) j_ff <= i_next;
      else if (cmd.adv_j) j_ff <= j_next;
      if (cmd.q_start) k_ff <= '0;
      else if (cmd.q_scan) k_ff <= k_next;
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_coll_ff   <= coll_ff;
         rsp_count_ff  <= count_ff;
         rsp_pairs_ff  <= pairs_ff;
         rsp_ovf_ff    <= ovf_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pairs_ff     <= '0;
         ovf_ff       <= '0;
         status_ff    <= ST_OK;
         coll_ff      <= 1'b0;
         cnt_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.ld_req) begin
            status_ff <= ST_OK;
            coll_ff   <= 1'b0;
         end
         if (cmd.set_full) status_ff <= ST_FULL;
         if (cmd.set_range) status_ff <= ST_RANGE;
         if (cmd.wr_box && action_ff == ACT_APPEND) count_ff <= count_ff + 1'b1;
         if (cmd.clear_all) count_ff <= '0;
         if (cmd.clear_all || cmd.upd_start) cnt_valid_ff <= '0;
         else if (cmd.wb_row) cnt_valid_ff[i_ff[IDX_W-1:0]] <= 1'b1;
         else if (cmd.rec_j) cnt_valid_ff[j_ff[IDX_W-1:0]] <= 1'b1;
         if (cmd.upd_start) begin
            pairs_ff <= '0;
            ovf_ff   <= '0;
         end
         if (cmd.rec_j && pairs_ff != PAIR_MAX) pairs_ff <= pairs_ff + 1'b1;
         if (cmd.count_ovf && ovf_ff != PAIR_MAX) ovf_ff <= ovf_ff + 1'b1;
         if (cmd.q_scan && HCNT_W'(k_ff) < cnt_rd_ff && list_rd_ff == ib_ff)
            coll_ff <= 1'b1;
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      stat.action    = action_ff;
      stat.full      = count_ff >= CNT_W'(MAX_BOXES);
      stat.bad_a     = {1'b0, ia_ff} >= count_ff;
      stat.bad_q     = ({1'b0, ia_ff} >= count_ff) || ({1'b0, ib_ff} >= count_ff);
      stat.rows_done = i_ff >= count_ff;
      stat.row_en    = box_rd_ff.en;
      stat.row_end   = j_ff >= count_ff;
      stat.pair_hit  = box_rd_ff.en && overlap;
      stat.room      = (cnt_i_ff < HCNT_W'(MAX_HITS)) && (cnt_rd_ff < HCNT_W'(MAX_HITS));
      stat.q_last    = k_ff == HIDX_W'(MAX_HITS - 1);
      stat.rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.collided       = rsp_coll_ff;
   assign rsp_chan.box_count      = rsp_count_ff;
   assign rsp_chan.pair_count     = rsp_pairs_ff;
   assign rsp_chan.overflow_count = rsp_ovf_ff;
endmodule
`default_nettype wire

// File: rtl/core/aabb_pairwise_collision_table_unit.sv
// Sequence: append/rewrite scale x, scale y and write the box; clear, rejected or unused actions
// go straight to done; query scans the hit list; every result then loads the output register.
// Update tests one pair at a time through the single read port of the box store; a hit adds a step.
// One transaction at a time; a new request is taken while a response waits.
// Synchronous reset empties the table, zeroes the box, pair and overflow counters and hit counts.
// Box store and hit lists are not cleared; only written entries are read.
`default_nettype none
module aabb_pairwise_collision_table_unit
   import aabb_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   aabb_req_if.sink   req_chan,
   aabb_rsp_if.source rsp_chan
);
   cmd_type  cmd;
   stat_type stat;

   aabb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   aabb_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

   assign req_chan.ready = cmd.req_ready;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.box_count <= CNT_W'(MAX_BOXES))
      else $error("box count beyond table size");

   a_coll_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.collided |-> rsp_chan.status == ST_OK)
      else $error("collision reported with error status");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_req |=> !req_chan.ready)
      else $error("request taken while busy");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("response valid right after reset");
endmodule
`default_nettype wire

// File: test/aabb_pairwise_collision_table_unit_test.sv
// Testbench: directed and randomized box table traffic checked against a built-in predictor.
`timescale 1ns / 100ps
`default_nettype none
module aabb_pairwise_collision_table_unit_test;
   import aabb_pkg::*;

   localparam logic [2:0] ACT_SPARE_LO = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam int STALL_LIMIT = 20000;
   localparam int QUIET_FROM  = 1500;
   localparam int QUIET_TO    = 2500;
   localparam int HOLD_AT     = 1000;
   localparam int HOLD_LEN    = 400;

   typedef struct {
      logic [2:0]         action;
      logic [5:0]         index_a;
      logic [5:0]         index_b;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [30:0]        size_x;
      logic [30:0]        size_y;
      logic               enabled;
      logic               has_parent;
      logic signed [31:0] parent_x;
      logic signed [31:0] parent_y;
      logic [15:0]        parent_scale;
   } box_cmd_type;

   typedef struct {
      logic [1:0]  status;
      logic        collided;
      logic [6:0]  box_count;
      logic [10:0] pair_count;
      logic [10:0] overflow_count;
   } table_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   aabb_req_if req_chan ();
   aabb_rsp_if rsp_chan ();

   aabb_pairwise_collision_table_unit dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   longint      world_x [MAX_BOXES];
   longint      world_y [MAX_BOXES];
   logic [30:0] box_w [MAX_BOXES];
   logic [30:0] box_h [MAX_BOXES];
   logic        box_on [MAX_BOXES];
   int          hits [MAX_BOXES];
   int          hit_ids [MAX_BOXES][MAX_HITS];
   int          boxes_held = 0;
   int          pairs_seen = 0;
   int          pairs_dropped = 0;

   box_cmd_type     pending_cmds [$];
   table_reply_type expected_replies [$];
   int              mismatches = 0;
   int              idle_cycles = 0;
   int              cycle_no = 0;
   int              hold_left = 0;
   logic            req_taken = 1'b0;
   logic            timed_out = 1'b0;

   function automatic longint place_coord(logic signed [31:0] loc, logic signed [31:0] par,
                                          logic [15:0] scale, logic parented);
      longint v;
      v = loc;
      if (parented) v = longint'(par) + ((longint'(loc) * longint'({1'b0, scale})) >>> 8);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v;
   endfunction

   function automatic void store_box(int slot, box_cmd_type c);
      world_x[slot] = place_coord(c.pos_x, c.parent_x, c.parent_scale, c.has_parent);
      world_y[slot] = place_coord(c.pos_y, c.parent_y, c.parent_scale, c.has_parent);
      box_w[slot] = c.size_x;
      box_h[slot] = c.size_y;
      box_on[slot] = c.enabled;
   endfunction

   function automatic bit boxes_touch(int a, int b);
      return world_x[a] < world_x[b] + longint'(box_w[b]) &&
             world_x[a] + longint'(box_w[a]) > world_x[b] &&
             world_y[a] < world_y[b] + longint'(box_h[b]) &&
             world_y[a] + longint'(box_h[a]) > world_y[b];
   endfunction

   function automatic table_reply_type apply_table_cmd(box_cmd_type c);
      table_reply_type r;
      int ia, ib;
      ia = c.index_a;
      ib = c.index_b;
      r.status = ST_OK;
      r.collided = 1'b0;
      case (c.action)
         ACT_APPEND: begin
            if (boxes_held >= MAX_BOXES) r.status = ST_FULL;
            else begin
               store_box(boxes_held, c);
               boxes_held++;
            end
         end
         ACT_REWRITE: begin
            if (ia >= boxes_held) r.status = ST_RANGE;
            else store_box(ia, c);
         end
         ACT_CLEAR: begin
            boxes_held = 0;
            foreach (hits[i]) hits[i] = 0;
         end
         ACT_UPDATE: begin
            pairs_seen = 0;
            pairs_dropped = 0;
            foreach (hits[i]) hits[i] = 0;
            for (int i = 0; i < boxes_held; i++) begin
               if (!box_on[i]) continue;
               for (int j = i + 1; j < boxes_held; j++) begin
                  if (!box_on[j] || !boxes_touch(i, j)) continue;
                  if (hits[i] < MAX_HITS && hits[j] < MAX_HITS) begin
                     hit_ids[i][hits[i]] = j;
                     hits[i]++;
                     hit_ids[j][hits[j]] = i;
                     hits[j]++;
                     if (pairs_seen < 2047) pairs_seen++;
                  end else if (pairs_dropped < 2047) pairs_dropped++;
               end
            end
         end
         ACT_QUERY: begin
            if (ia >= boxes_held || ib >= boxes_held) r.status = ST_RANGE;
            else for (int k = 0; k < hits[ia]; k++)
               if (hit_ids[ia][k] == ib) r.collided = 1'b1;
         end
         default: ;
      endcase
      r.box_count = 7'(boxes_held);
      r.pair_count = 11'(pairs_seen);
      r.overflow_count = 11'(pairs_dropped);
      return r;
   endfunction

   function automatic box_cmd_type blank_cmd(logic [2:0] act);
      box_cmd_type c;
      c.action = act;
      c.index_a = 6'($urandom);
      c.index_b = 6'($urandom);
      c.pos_x = $urandom;
      c.pos_y = $urandom;
      c.size_x = 31'($urandom);
      c.size_y = 31'($urandom);
      c.enabled = 1'($urandom);
      c.has_parent = 1'($urandom);
      c.parent_x = $urandom;
      c.parent_y = $urandom;
      c.parent_scale = 16'($urandom);
      return c;
   endfunction

   // mostly small boxes packed near the origin so that lists fill up
   function automatic box_cmd_type near_box(logic [2:0] act, int spread);
      box_cmd_type c;
      c = blank_cmd(act);
      if ($urandom_range(9) != 0) begin
         c.pos_x = $signed($urandom_range(0, 2 * spread)) - spread;
         c.pos_y = $signed($urandom_range(0, 2 * spread)) - spread;
         c.size_x = 31'($urandom_range(0, 32'h30000));
         c.size_y = 31'($urandom_range(0, 32'h30000));
         c.enabled = ($urandom_range(9) != 0);
         c.parent_x = $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
         c.parent_y = $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
         c.parent_scale = ($urandom_range(1) != 0) ? 16'h0100 : 16'($urandom_range(0, 16'h0300));
      end
      return c;
   endfunction

   function automatic bit quiet_now();
      return cycle_no >= QUIET_FROM && cycle_no < QUIET_TO;
   endfunction

   // request driver
   always @(negedge clock) begin
      cycle_no++;
      if (!reset && (!req_chan.valid || req_taken)) begin
         req_taken = 1'b0;
         if (pending_cmds.size() > 0 && (quiet_now() || $urandom_range(99) >= 7)) begin
            box_cmd_type c;
            c = pending_cmds.pop_front();
            req_chan.action = c.action;
            req_chan.index_a = c.index_a;
            req_chan.index_b = c.index_b;
            req_chan.pos_x = c.pos_x;
            req_chan.pos_y = c.pos_y;
            req_chan.size_x = c.size_x;
            req_chan.size_y = c.size_y;
            req_chan.enabled = c.enabled;
            req_chan.has_parent = c.has_parent;
            req_chan.parent_x = c.parent_x;
            req_chan.parent_y = c.parent_y;
            req_chan.parent_scale = c.parent_scale;
            req_chan.valid = 1'b1;
         end else req_chan.valid = 1'b0;
      end
   end

   // response ready, with one long hold-off to back up the input
   always @(negedge clock) begin
      if (cycle_no == HOLD_AT) hold_left = HOLD_LEN;
      if (reset) rsp_chan.ready = 1'b0;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready = 1'b0;
      end else rsp_chan.ready = quiet_now() || $urandom_range(99) >= 7;
   end

   // predict on each accepted request
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         box_cmd_type c;
         c.action = req_chan.action;
         c.index_a = req_chan.index_a;
         c.index_b = req_chan.index_b;
         c.pos_x = req_chan.pos_x;
         c.pos_y = req_chan.pos_y;
         c.size_x = req_chan.size_x;
         c.size_y = req_chan.size_y;
         c.enabled = req_chan.enabled;
         c.has_parent = req_chan.has_parent;
         c.parent_x = req_chan.parent_x;
         c.parent_y = req_chan.parent_y;
         c.parent_scale = req_chan.parent_scale;
         expected_replies.push_back(apply_table_cmd(c));
         req_taken = 1'b1;
      end
   end

   // check each accepted response
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         table_reply_type e;
         if (expected_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response transaction");
         end else begin
            e = expected_replies.pop_front();
            if (rsp_chan.status !== e.status || rsp_chan.collided !== e.collided ||
                rsp_chan.box_count !== e.box_count || rsp_chan.pair_count !== e.pair_count ||
                rsp_chan.overflow_count !== e.overflow_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp st=%0d hit=%0d n=%0d pr=%0d ov=%0d, ",
                            "got st=%0d hit=%0d n=%0d pr=%0d ov=%0d"},
                           e.status, e.collided, e.box_count, e.pair_count, e.overflow_count,
                           rsp_chan.status, rsp_chan.collided, rsp_chan.box_count,
                           rsp_chan.pair_count, rsp_chan.overflow_count);
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("aabb_pairwise_collision_table_unit regression: fail");
         $finish;
      end
   end

   initial begin
      box_cmd_type c;
      int planned, n, spread;
      req_chan.valid = 1'b0;
      req_chan.action = ACT_APPEND;
      req_chan.index_a = '0;
      req_chan.index_b = '0;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      req_chan.size_x = '0;
      req_chan.size_y = '0;
      req_chan.enabled = 1'b0;
      req_chan.has_parent = 1'b0;
      req_chan.parent_x = '0;
      req_chan.parent_y = '0;
      req_chan.parent_scale = '0;
      rsp_chan.ready = 1'b0;
      foreach (hits[i]) hits[i] = 0;

      // directed: query on empty table, extreme boxes, saturation both ways
      pending_cmds.push_back(blank_cmd(ACT_QUERY));
      c = blank_cmd(ACT_APPEND);
      c.pos_x = 32'sh7fffffff; c.pos_y = 32'sh7fffffff; c.has_parent = 1'b1;
      c.parent_x = 32'sh7fffffff; c.parent_y = 32'sh7fffffff; c.parent_scale = 16'hffff;
      c.size_x = 31'h7fffffff; c.size_y = 31'h7fffffff; c.enabled = 1'b1;
      pending_cmds.push_back(c);
      c.pos_x = 32'sh80000000; c.pos_y = 32'sh80000000;
      c.parent_x = 32'sh80000000; c.parent_y = 32'sh80000000;
      pending_cmds.push_back(c);
      c.pos_x = 32'sh7fffffff; c.pos_y = 32'sh80000000; c.has_parent = 1'b0;
      c.size_x = '0; c.size_y = '0;
      pending_cmds.push_back(c);
      c = blank_cmd(ACT_APPEND);
      c.pos_x = '0; c.pos_y = '0; c.size_x = 31'h10000; c.size_y = 31'h10000;
      c.enabled = 1'b1; c.has_parent = 1'b0;
      pending_cmds.push_back(c);
      // touching edge: not an overlap
      c.pos_x = 32'sh10000;
      pending_cmds.push_back(c);
      c.pos_x = 32'sh8000; c.enabled = 1'b0;
      pending_cmds.push_back(c);
      pending_cmds.push_back(blank_cmd(ACT_UPDATE));
      for (int a = 0; a < 4; a++) begin
         c = blank_cmd(ACT_QUERY);
         c.index_a = 6'(a); c.index_b = 6'((a + 1) % 7);
         pending_cmds.push_back(c);
      end
      c.index_a = 6'd3; c.index_b = 6'd3;
      pending_cmds.push_back(c);
      c.index_a = 6'd63; c.index_b = 6'd0;
      pending_cmds.push_back(c);
      c.index_a = 6'd0; c.index_b = 6'd63;
      pending_cmds.push_back(c);
      // rewrite keeps the hit list until the next update
      c = blank_cmd(ACT_REWRITE);
      c.index_a = 6'd4; c.enabled = 1'b1; c.has_parent = 1'b1; c.parent_scale = 16'h0000;
      c.parent_x = 32'sh40000000; c.parent_y = '0; c.size_x = 31'd1; c.size_y = 31'd1;
      pending_cmds.push_back(c);
      c = blank_cmd(ACT_QUERY); c.index_a = 6'd4; c.index_b = 6'd5;
      pending_cmds.push_back(c);
      c = blank_cmd(ACT_REWRITE); c.index_a = 6'd63;
      pending_cmds.push_back(c);
      pending_cmds.push_back(blank_cmd(ACT_SPARE_LO));
      pending_cmds.push_back(blank_cmd(ACT_SPARE_HI));
      pending_cmds.push_back(blank_cmd(ACT_UPDATE));
      pending_cmds.push_back(blank_cmd(ACT_CLEAR));
      c = blank_cmd(ACT_QUERY); c.index_a = 6'd0; c.index_b = 6'd0;
      pending_cmds.push_back(c);
      pending_cmds.push_back(blank_cmd(ACT_UPDATE));
      planned = pending_cmds.size();

      // random phases: clear, fill, update, then twice: probe, disturb, update
      while (planned < 265) begin
         n = ($urandom_range(7) == 0) ? MAX_BOXES + $urandom_range(1, 3) : $urandom_range(2, 12);
         spread = ($urandom_range(2) == 0) ? 32'h4000 : 32'h40000;
         pending_cmds.push_back(blank_cmd(ACT_CLEAR));
         for (int k = 0; k < n; k++) pending_cmds.push_back(near_box(ACT_APPEND, spread));
         pending_cmds.push_back(blank_cmd(ACT_UPDATE));
         if (n > MAX_BOXES) n = MAX_BOXES;
         for (int r = 0; r < 2; r++) begin
            for (int k = 0; k < $urandom_range(4, 10); k++) begin
               c = blank_cmd(ACT_QUERY);
               if ($urandom_range(9) != 0) begin
                  c.index_a = 6'($urandom_range(n - 1));
                  c.index_b = ($urandom_range(9) == 0) ? c.index_a : 6'($urandom_range(n - 1));
               end
               pending_cmds.push_back(c);
            end
            for (int k = 0; k < $urandom_range(0, 3); k++) begin
               c = near_box(ACT_REWRITE, spread);
               c.index_a = ($urandom_range(5) == 0) ? 6'($urandom) : 6'($urandom_range(n - 1));
               pending_cmds.push_back(c);
            end
            if ($urandom_range(5) == 0)
               pending_cmds.push_back(blank_cmd(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI))));
            pending_cmds.push_back(blank_cmd(ACT_UPDATE));
         end
         planned = pending_cmds.size();
      end

      repeat (8) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // drain: everything sent, every reply seen, then let the block settle
      while (pending_cmds.size() != 0 || req_chan.valid || expected_replies.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_replies.size() == 0)
         $display("aabb_pairwise_collision_table_unit regression: pass");
      else
         $display("aabb_pairwise_collision_table_unit regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
rtl/core/aabb_pkg.sv
rtl/core/aabb_if.sv
rtl/core/aabb_ctrl.sv
rtl/core/aabb_dpath.sv
rtl/core/aabb_pairwise_collision_table_unit.sv
test/aabb_pairwise_collision_table_unit_test.sv
